FILE: sv/msof_pkg.sv
`timescale 1ns / 1ps
package msof_pkg;

	localparam int MIP_W       = 5;
	localparam int LAYER_W     = 11;
	localparam int FACE_W      = 3;
	localparam int IDX_W       = 14;
	localparam int PL_W        = 15;
	localparam int FIELD_W     = 52;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 104;
	localparam int APB_AW      = 6;
	localparam int APB_DW      = 64;

	typedef enum logic [2:0] {
		REG_WIDTH,
		REG_HEIGHT,
		REG_FORMAT,
		REG_MIPS,
		REG_LAYERS,
		REG_FACES,
		REG_LENGTH
	} reg_idx_t;

	typedef enum logic [2:0] {
		FMT_UNKNOWN = 3'd0,
		FMT_PX16    = 3'd1,
		FMT_PX4_A   = 3'd2,
		FMT_PX4_B   = 3'd3,
		FMT_PX4_C   = 3'd4
	} fmt_code_t;

	typedef struct packed {
		logic [15:0]        width;
		logic [15:0]        height;
		logic [2:0]         fmt;
		logic [4:0]         mip_count;
		logic [11:0]        layer_count;
		logic [2:0]         face_count;
		logic [FIELD_W-1:0] data_length;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		width:       16'd0,
		height:      16'd0,
		fmt:         3'd0,
		mip_count:   5'd1,
		layer_count: 12'd1,
		face_count:  3'd1,
		data_length: 52'd0
	};

	typedef struct packed {
		logic             in_range;
		logic             is_last;
		logic [MIP_W-1:0] mip;
		logic [IDX_W-1:0] idx;
		logic [PL_W-1:0]  per_level;
	} ctl_t;

	// pixel size as a shift; en low means size 0
	typedef struct packed {
		logic       en;
		logic [2:0] sh;
	} fmt_t;

	function automatic fmt_t fmt_decode(input logic [2:0] code);
		fmt_t r;
		r = '0;
		unique case (code) inside
			FMT_PX16: begin
				r.en = 1'b1;
				r.sh = 3'd4;
			end
			FMT_PX4_A, FMT_PX4_B, FMT_PX4_C: begin
				r.en = 1'b1;
				r.sh = 3'd2;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/msof_cfg_regs.sv
`timescale 1ns / 1ps
module msof_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [msof_pkg::APB_AW-1:0]    paddr,
	input  logic [msof_pkg::APB_DW-1:0]    pwdata,
	output logic [msof_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,
	output msof_pkg::cfg_t                 cfg
);
	import msof_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr_en;

	assign pready = 1'b1;
	assign sel    = reg_idx_t'(paddr[APB_AW-1:3]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (sel)
				REG_WIDTH:  cfg_q.width       <= pwdata[15:0];
				REG_HEIGHT: cfg_q.height      <= pwdata[15:0];
				REG_FORMAT: cfg_q.fmt         <= pwdata[2:0];
				REG_MIPS:   cfg_q.mip_count   <= pwdata[4:0];
				REG_LAYERS: cfg_q.layer_count <= pwdata[11:0];
				REG_FACES:  cfg_q.face_count  <= pwdata[2:0];
				REG_LENGTH: cfg_q.data_length <= pwdata[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_WIDTH:  prdata = APB_DW'(cfg_q.width);
			REG_HEIGHT: prdata = APB_DW'(cfg_q.height);
			REG_FORMAT: prdata = APB_DW'(cfg_q.fmt);
			REG_MIPS:   prdata = APB_DW'(cfg_q.mip_count);
			REG_LAYERS: prdata = APB_DW'(cfg_q.layer_count);
			REG_FACES:  prdata = APB_DW'(cfg_q.face_count);
			REG_LENGTH: prdata = APB_DW'(cfg_q.data_length);
			default:    prdata = '0;
		endcase
	end

endmodule

FILE: sv/msof_entry.sv
`timescale 1ns / 1ps
module msof_entry #(
	parameter int MAX_MIP_LEVELS = 17,
	parameter int DIM_BITS       = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  msof_pkg::cfg_t                    cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [msof_pkg::IN_TDATA_W-1:0]   in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output msof_pkg::ctl_t                    out_ctl,
	output logic [DIM_BITS-1:0]               out_w,
	output logic [DIM_BITS-1:0]               out_h
);
	import msof_pkg::*;

	localparam logic [5:0] MIPS_MAX = 6'(MAX_MIP_LEVELS);

	logic [MIP_W-1:0]   mip;
	logic [LAYER_W-1:0] layer;
	logic [FACE_W-1:0]  face;
	logic [5:0]         mips;
	logic [5:0]         mip_x;
	logic [11:0]        layer_x;
	logic [IDX_W-1:0]   layer_i;
	logic [IDX_W-1:0]   face_i;
	logic [IDX_W-1:0]   fc_i;
	logic [PL_W-1:0]    lc_p;
	logic [PL_W-1:0]    fc_p;
	ctl_t               ctl;
	logic               en;

	logic                valid_s1;
	ctl_t                ctl_s1;
	logic [DIM_BITS-1:0] w_s1;
	logic [DIM_BITS-1:0] h_s1;

	assign mip   = in_data[MIP_W-1:0];
	assign layer = in_data[MIP_W+LAYER_W-1:MIP_W];
	assign face  = in_data[MIP_W+LAYER_W+FACE_W-1:MIP_W+LAYER_W];

	assign mip_x   = {1'b0, mip};
	assign layer_x = {1'b0, layer};
	assign mips    = ({1'b0, cfg.mip_count} > MIPS_MAX) ? MIPS_MAX : {1'b0, cfg.mip_count};
	assign layer_i = IDX_W'(layer);
	assign face_i  = IDX_W'(face);
	assign fc_i    = IDX_W'(cfg.face_count);
	assign lc_p    = PL_W'(cfg.layer_count);
	assign fc_p    = PL_W'(cfg.face_count);

	always_comb begin
		ctl.in_range  = (mip_x < mips) && (layer_x < cfg.layer_count)
			&& (face < cfg.face_count);
		ctl.is_last   = (mip_x == mips - 6'd1) && (layer_x == cfg.layer_count - 12'd1)
			&& (face == cfg.face_count - 3'd1);
		ctl.mip       = mip;
		ctl.idx       = layer_i * fc_i + face_i;
		ctl.per_level = lc_p * fc_p;
	end

	assign en       = !valid_s1 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ctl_s1 <= ctl;
			w_s1   <= DIM_BITS'(cfg.width);
			h_s1   <= DIM_BITS'(cfg.height);
		end
	end

	assign out_valid = valid_s1;
	assign out_ctl   = ctl_s1;
	assign out_w     = w_s1;
	assign out_h     = h_s1;

endmodule

FILE: sv/msof_level.sv
`timescale 1ns / 1ps
module msof_level #(
	parameter int LEVEL       = 0,
	parameter int DIM_BITS    = 16,
	parameter int OFFSET_BITS = 52
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  msof_pkg::ctl_t            in_ctl,
	input  logic [DIM_BITS-1:0]       in_w,
	input  logic [DIM_BITS-1:0]       in_h,
	input  logic [OFFSET_BITS-1:0]    in_sum,
	input  logic [2*DIM_BITS-1:0]     in_area,
	output logic                      out_valid,
	input  logic                      out_ready,
	output msof_pkg::ctl_t            out_ctl,
	output logic [DIM_BITS-1:0]       out_w,
	output logic [DIM_BITS-1:0]       out_h,
	output logic [OFFSET_BITS-1:0]    out_sum,
	output logic [2*DIM_BITS-1:0]     out_area
);
	import msof_pkg::*;

	localparam int               AW  = 2 * DIM_BITS;
	localparam logic [MIP_W-1:0] LVL = MIP_W'(LEVEL);
	localparam logic [DIM_BITS-1:0] ONE = DIM_BITS'(1);

	logic [AW-1:0] area;
	logic          en;

	logic                   valid_s1;
	ctl_t                   ctl_s1;
	logic [DIM_BITS-1:0]    w_s1;
	logic [DIM_BITS-1:0]    h_s1;
	logic [OFFSET_BITS-1:0] sum_s1;
	logic [AW-1:0]          area_s1;

	assign area     = AW'(in_w) * AW'(in_h);
	assign en       = !valid_s1 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	// levels below the requested one add their area, the requested one is captured
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ctl_s1  <= in_ctl;
			w_s1    <= (in_w > ONE) ? (in_w >> 1) : ONE;
			h_s1    <= (in_h > ONE) ? (in_h >> 1) : ONE;
			sum_s1  <= (in_ctl.mip > LVL) ? in_sum + OFFSET_BITS'(area) : in_sum;
			area_s1 <= (in_ctl.mip == LVL) ? area : in_area;
		end
	end

	assign out_valid = valid_s1;
	assign out_ctl   = ctl_s1;
	assign out_w     = w_s1;
	assign out_h     = h_s1;
	assign out_sum   = sum_s1;
	assign out_area  = area_s1;

endmodule

FILE: sv/msof_finish.sv
`timescale 1ns / 1ps
module msof_finish #(
	parameter int DIM_BITS    = 16,
	parameter int OFFSET_BITS = 52
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  msof_pkg::cfg_t                    cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  msof_pkg::ctl_t                    in_ctl,
	input  logic [OFFSET_BITS-1:0]            in_sum,
	input  logic [2*DIM_BITS-1:0]             in_area,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [msof_pkg::OUT_TDATA_W-1:0]  out_data,
	output logic                              out_user
);
	import msof_pkg::*;

	localparam int OB = OFFSET_BITS;
	localparam int CW = (OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W;

	logic en1, en2, en3;
	fmt_t fmt;
	logic [OB-1:0] tot;
	logic [CW-1:0] dl_x;
	logic [CW-1:0] off_x;
	logic [CW-1:0] sz_last;
	logic [CW-1:0] sz;

	logic          valid_s1, valid_s2, valid_s3;
	ctl_t          ctl_s1, ctl_s2;
	logic [OB-1:0] ps_s1;
	logic [OB-1:0] ia_s1;
	logic [OB-1:0] area_s1;
	logic [OB-1:0] off_s2;
	logic [OB-1:0] lsz_s2;
	logic               range_s3;
	logic [FIELD_W-1:0] off_s3;
	logic [FIELD_W-1:0] size_s3;

	assign en3      = !valid_s3 || out_ready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: level sum times subimages per level, index times level area
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			ctl_s1  <= in_ctl;
			ps_s1   <= OB'(in_ctl.per_level) * in_sum;
			ia_s1   <= OB'(in_ctl.idx) * OB'(in_area);
			area_s1 <= OB'(in_area);
		end
	end

	// stage 2: scale pixel counts to bytes
	assign fmt = fmt_decode(cfg.fmt);
	assign tot = ps_s1 + ia_s1;

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			ctl_s2 <= ctl_s1;
			off_s2 <= fmt.en ? (tot << fmt.sh) : '0;
			lsz_s2 <= fmt.en ? (area_s1 << fmt.sh) : '0;
		end
	end

	// stage 3: last subimage takes the rest of the buffer
	assign dl_x    = CW'(cfg.data_length);
	assign off_x   = CW'(off_s2);
	assign sz_last = (dl_x >= off_x) ? dl_x - off_x : '0;
	assign sz      = ctl_s2.is_last ? sz_last : CW'(lsz_s2);

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			range_s3 <= ctl_s2.in_range;
			off_s3   <= ctl_s2.in_range ? FIELD_W'(off_x) : '0;
			size_s3  <= ctl_s2.in_range ? FIELD_W'(sz) : '0;
		end
	end

	assign out_valid = valid_s3;
	assign out_user  = range_s3;
	assign out_data  = {size_s3, off_s3};

endmodule

FILE: sv/mipmap_subimage_offset_unit.sv
`timescale 1ns / 1ps
// Subimage locator for a packed texture (mip-major, then layer, then face).
// Program the layout over the APB port (64-bit data, register i at byte 8*i):
// width, height, format, mip count, layer count, face count, buffer length.
// Requests enter on s_axis: tdata holds mip level, layer index, face index.
// Results leave on m_axis: tdata holds byte offset then byte size,
// tuser flags a request inside the configured counts (else both are zero).
// One result per request, in order.
// The pipeline is one entry stage, one stage per mip level accumulating level
// areas, then three stages for the scaling multiplies, the byte shift and the
// last-subimage size.
// A new request can enter every cycle unless every stage is full. Every stage
// holds its item while the next is full and stalled, so a stall at m_axis fills
// empty stages first, only then drops s_axis_tready; nothing dropped or repeated.
// Reset empties the pipeline and returns the registers to their defaults;
// the block takes requests as soon as reset is released.
module mipmap_subimage_offset_unit #(
	parameter int MAX_MIP_LEVELS = 17,
	parameter int DIM_BITS       = 16,
	parameter int OFFSET_BITS    = 52
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [msof_pkg::APB_AW-1:0]       paddr,
	input  logic [msof_pkg::APB_DW-1:0]       pwdata,
	output logic [msof_pkg::APB_DW-1:0]       prdata,
	output logic                              pready,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [4:0] mip_level, [15:5] layer_index, [18:16] face_index, [23:19] zero
	input  logic [msof_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [51:0] byte_offset, [103:52] byte_size
	output logic [msof_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	// [0] in_range
	output logic                              m_axis_tuser
);
	import msof_pkg::*;

	localparam int AW = 2 * DIM_BITS;

	cfg_t cfg;
	fmt_t fmt_chk;

	logic                   v   [0:MAX_MIP_LEVELS];
	logic                   rdy [0:MAX_MIP_LEVELS];
	ctl_t                   ctl [0:MAX_MIP_LEVELS];
	logic [DIM_BITS-1:0]    w   [0:MAX_MIP_LEVELS];
	logic [DIM_BITS-1:0]    h   [0:MAX_MIP_LEVELS];
	logic [OFFSET_BITS-1:0] sum [0:MAX_MIP_LEVELS];
	logic [AW-1:0]          area[0:MAX_MIP_LEVELS];

	msof_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	msof_entry #(
		.MAX_MIP_LEVELS (MAX_MIP_LEVELS),
		.DIM_BITS       (DIM_BITS)
	) u_entry (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (v[0]),
		.out_ready (rdy[0]),
		.out_ctl   (ctl[0]),
		.out_w     (w[0]),
		.out_h     (h[0])
	);

	assign sum[0]  = '0;
	assign area[0] = '0;

	for (genvar g = 0; g < MAX_MIP_LEVELS; g++) begin : g_level
		msof_level #(
			.LEVEL       (g),
			.DIM_BITS    (DIM_BITS),
			.OFFSET_BITS (OFFSET_BITS)
		) u_level (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[g]),
			.in_ready  (rdy[g]),
			.in_ctl    (ctl[g]),
			.in_w      (w[g]),
			.in_h      (h[g]),
			.in_sum    (sum[g]),
			.in_area   (area[g]),
			.out_valid (v[g+1]),
			.out_ready (rdy[g+1]),
			.out_ctl   (ctl[g+1]),
			.out_w     (w[g+1]),
			.out_h     (h[g+1]),
			.out_sum   (sum[g+1]),
			.out_area  (area[g+1])
		);
	end

	msof_finish #(
		.DIM_BITS    (DIM_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (v[MAX_MIP_LEVELS]),
		.in_ready  (rdy[MAX_MIP_LEVELS]),
		.in_ctl    (ctl[MAX_MIP_LEVELS]),
		.in_sum    (sum[MAX_MIP_LEVELS]),
		.in_area   (area[MAX_MIP_LEVELS]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

	assign fmt_chk = fmt_decode(cfg.fmt);

	// an empty output stage means every stage can move
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("request refused while output stage empty");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("out-of-range request with nonzero offset or size");

	a_unknown_fmt_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser && !fmt_chk.en)
		|-> (m_axis_tdata[FIELD_W-1:0] == '0))
		else $error("nonzero offset with unknown pixel format");

endmodule

FILE: verif/mipmap_subimage_offset_unit_tb.sv
`timescale 1ns / 1ps
module mipmap_subimage_offset_unit_tb;
	import msof_pkg::*;

	localparam int MAX_LEVELS = 17;
	localparam int LATENCY = MAX_LEVELS + 4;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 10;
	localparam int PHASE_REQS = 140;
	localparam logic [63:0] MASK52 = (64'd1 << 52) - 64'd1;

	typedef struct packed {
		logic        in_range;
		logic [51:0] off;
		logic [51:0] size;
	} locate_t;

	typedef struct {
		int          sel;
		logic [4:0]  mip;
		logic [10:0] layer;
		logic [2:0]  face;
		bit          pinned;
		logic        in_range;
		logic [51:0] off;
		logic [51:0] size;
	} probe_t;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_AW-1:0]      paddr;
	logic [APB_DW-1:0]      pwdata;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// [4:0] mip_level, [15:5] layer_index, [18:16] face_index, [23:19] zero
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// [51:0] byte_offset, [103:52] byte_size
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// [0] in_range
	logic                   m_axis_tuser;

	cfg_t        layout = CFG_RESET;
	locate_t     pending_locs [$];
	bit          pin_on = 1'b0;
	locate_t     pin_res = '0;
	bit          calm = 1'b0;
	int          errors = 0;
	int unsigned idle_cycles = 0;

	cfg_t probe_layouts [7] = '{
		CFG_RESET,
		'{16'hFFFF, 16'hFFFF, FMT_PX16, 5'd17, 12'd2048, 3'd6, {52{1'b1}}},
		'{16'd5, 16'd3, FMT_PX4_A, 5'd0, 12'd3, 3'd2, 52'd1000},
		'{16'd7, 16'd9, 3'd7, 5'd31, 12'd1, 3'd1, 52'd12345},
		'{16'hFFFF, 16'hFFFF, FMT_PX16, 5'd17, 12'd2048, 3'd6, 52'd0},
		'{16'd1, 16'd1, FMT_PX4_C, 5'd2, 12'd0, 3'd0, 52'd64},
		'{16'd3, 16'd5, FMT_PX4_B, 5'd3, 12'd2, 3'd3, 52'd500}
	};

	probe_t probes [23] = '{
		'{0, 0, 0, 0, 1, 1, 0, 0},
		'{0, 1, 0, 0, 1, 0, 0, 0},
		'{0, 0, 1, 0, 1, 0, 0, 0},
		'{0, 0, 0, 1, 1, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0, 0},
		'{1, 16, 2047, 5, 0, 0, 0, 0},
		'{1, 16, 0, 0, 0, 0, 0, 0},
		'{1, 8, 1024, 3, 0, 0, 0, 0},
		'{1, 17, 0, 0, 1, 0, 0, 0},
		'{1, 0, 0, 6, 1, 0, 0, 0},
		'{1, 31, 2047, 7, 1, 0, 0, 0},
		'{2, 0, 0, 0, 1, 0, 0, 0},
		'{2, 1, 2, 1, 1, 0, 0, 0},
		'{3, 16, 0, 0, 1, 1, 0, 12345},
		'{3, 17, 0, 0, 1, 0, 0, 0},
		'{3, 5, 0, 0, 0, 0, 0, 0},
		'{4, 16, 2047, 5, 0, 0, 0, 0},
		'{4, 0, 0, 0, 0, 0, 0, 0},
		'{5, 0, 0, 0, 1, 0, 0, 0},
		'{6, 0, 0, 0, 0, 0, 0, 0},
		'{6, 2, 1, 2, 0, 0, 0, 0},
		'{6, 1, 1, 1, 0, 0, 0, 0},
		'{6, 2, 0, 0, 0, 0, 0, 0}
	};

	mipmap_subimage_offset_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// bytes of one subimage at the given level size
	function automatic logic [63:0] level_area(input logic [2:0] fmt, input logic [63:0] w,
			input logic [63:0] h);
		logic [63:0] px, align, pitch, area;
		px = 64'd0;
		align = 64'd0;
		case (fmt)
			FMT_PX16: begin
				px = 64'd16;
				align = 64'd4;
			end
			FMT_PX4_A, FMT_PX4_B, FMT_PX4_C: begin
				px = 64'd4;
				align = 64'd4;
			end
			default: ;
		endcase
		pitch = (w * px + align - 64'd1) & (64'd0 - align);
		area = (pitch * h) & MASK52;
		area = (area + 64'd3) & ~64'd3;
		return area & MASK52;
	endfunction

	function automatic locate_t locate(input cfg_t c, input logic [4:0] mip,
			input logic [10:0] layer, input logic [2:0] face);
		locate_t r;
		logic [63:0] mips, per_level, w, h, off, lsz, slot;
		r = '0;
		mips = (c.mip_count > MAX_LEVELS) ? 64'(MAX_LEVELS) : 64'(c.mip_count);
		if (mip >= mips || layer >= c.layer_count || face >= c.face_count)
			return r;
		per_level = 64'(c.layer_count) * 64'(c.face_count);
		w = 64'(c.width);
		h = 64'(c.height);
		off = 64'd0;
		for (int m = 0; m < mip; m++) begin
			off = (off + level_area(c.fmt, w, h) * per_level) & MASK52;
			w = (w > 64'd1) ? w >> 1 : 64'd1;
			h = (h > 64'd1) ? h >> 1 : 64'd1;
		end
		lsz = level_area(c.fmt, w, h);
		slot = 64'(layer) * 64'(c.face_count) + 64'(face);
		off = (off + slot * lsz) & MASK52;
		r.in_range = 1'b1;
		r.off = off[51:0];
		if (64'(mip) == mips - 64'd1 && 64'(layer) == 64'(c.layer_count) - 64'd1
				&& 64'(face) == 64'(c.face_count) - 64'd1)
			r.size = (c.data_length >= off[51:0]) ? c.data_length - off[51:0] : 52'd0;
		else
			r.size = lsz[51:0];
		return r;
	endfunction

	always @(posedge clk) begin
		locate_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (psel && penable && pwrite && pready) begin
				moved = 1'b1;
				case (reg_idx_t'(paddr[5:3]))
					REG_WIDTH:  layout.width = pwdata[15:0];
					REG_HEIGHT: layout.height = pwdata[15:0];
					REG_FORMAT: layout.fmt = pwdata[2:0];
					REG_MIPS:   layout.mip_count = pwdata[4:0];
					REG_LAYERS: layout.layer_count = pwdata[11:0];
					REG_FACES:  layout.face_count = pwdata[2:0];
					REG_LENGTH: layout.data_length = pwdata[51:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				moved = 1'b1;
				if (pin_on)
					want = pin_res;
				else
					want = locate(layout, s_axis_tdata[4:0], s_axis_tdata[15:5],
						s_axis_tdata[18:16]);
				pending_locs.push_back(want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				if (pending_locs.size() == 0) begin
					$display("%0t: unexpected result: in_range %0b offset %0d size %0d",
						$time, m_axis_tuser, m_axis_tdata[51:0], m_axis_tdata[103:52]);
					errors++;
				end else begin
					want = pending_locs.pop_front();
					if (m_axis_tuser !== want.in_range) begin
						$display("%0t: in_range expected %0b actual %0b",
							$time, want.in_range, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[51:0] !== want.off) begin
						$display("%0t: byte_offset expected %0d actual %0d",
							$time, want.off, m_axis_tdata[51:0]);
						errors++;
					end
					if (m_axis_tdata[103:52] !== want.size) begin
						$display("%0t: byte_size expected %0d actual %0d",
							$time, want.size, m_axis_tdata[103:52]);
						errors++;
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("** mipmap_subimage_offset_unit: FAILED **");
				$finish;
			end
		end
	end

	// result side backpressure
	initial begin
		int hold;
		hold = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm || (hold == 0 && $urandom_range(0, 11) != 0)) begin
				m_axis_tready <= 1'b1;
			end else begin
				if (hold == 0)
					hold = $urandom_range(1, 17);
				hold--;
				m_axis_tready <= 1'b0;
			end
		end
	end

	task automatic apb_write(input reg_idx_t idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
	endtask

	task automatic program_layout(input cfg_t c);
		apb_write(REG_WIDTH, 64'(c.width));
		apb_write(REG_HEIGHT, 64'(c.height));
		apb_write(REG_FORMAT, 64'(c.fmt));
		apb_write(REG_MIPS, 64'(c.mip_count));
		apb_write(REG_LAYERS, 64'(c.layer_count));
		apb_write(REG_FACES, 64'(c.face_count));
		apb_write(REG_LENGTH, 64'(c.data_length));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_query(input logic [4:0] mip, input logic [10:0] layer,
			input logic [2:0] face);
		if (!calm && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'd0, face, layer, mip};
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending_locs.size() != 0);
	endtask

	task automatic random_query();
		int mips, layers, pick;
		logic [4:0]  mip;
		logic [10:0] layer;
		logic [2:0]  face;
		mips = (layout.mip_count > MAX_LEVELS) ? MAX_LEVELS : int'(layout.mip_count);
		layers = (layout.layer_count > 2048) ? 2048 : int'(layout.layer_count);
		pick = $urandom_range(0, 99);
		mip = 5'($urandom);
		layer = 11'($urandom);
		face = 3'($urandom);
		if (mips != 0 && layers != 0 && layout.face_count != 0 && pick < 75) begin
			if (pick < 10) begin
				mip = 5'(mips - 1);
				layer = 11'(layers - 1);
				face = layout.face_count - 3'd1;
			end else begin
				mip = 5'($urandom_range(0, mips - 1));
				layer = 11'($urandom_range(0, layers - 1));
				face = 3'($urandom_range(0, layout.face_count - 1));
			end
		end
		send_query(mip, layer, face);
	endtask

	function automatic logic [15:0] pick_dim();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'd0;
		if (r == 1)
			return 16'hFFFF;
		if (r < 5)
			return 16'($urandom);
		return 16'($urandom_range(1, 64));
	endfunction

	function automatic cfg_t pick_layout(input int phase);
		cfg_t c;
		if (phase == 0)
			return probe_layouts[1];
		if (phase == 1)
			return '{16'd1, 16'd1, FMT_PX4_A, 5'd1, 12'd1, 3'd1, 52'd0};
		c.width = pick_dim();
		c.height = pick_dim();
		c.fmt = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom);
		c.mip_count = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(1, 17)) : 5'($urandom);
		case ($urandom_range(0, 9))
			0: c.layer_count = 12'd0;
			1, 2: c.layer_count = 12'($urandom_range(1, 4095));
			default: c.layer_count = 12'($urandom_range(1, 8));
		endcase
		c.face_count = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(1, 6)) : 3'($urandom);
		case ($urandom_range(0, 9))
			0, 1: c.data_length = {52{1'b1}};
			2, 3, 4: c.data_length = 52'($urandom_range(0, 1000000));
			default: c.data_length = {20'($urandom), $urandom};
		endcase
		return c;
	endfunction

	initial begin
		int cur_sel;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		cur_sel = 0;
		foreach (probes[i]) begin
			if (probes[i].sel != cur_sel) begin
				drain_results();
				program_layout(probe_layouts[probes[i].sel]);
				cur_sel = probes[i].sel;
			end
			pin_on = probes[i].pinned;
			pin_res = '{probes[i].in_range, probes[i].off, probes[i].size};
			send_query(probes[i].mip, probes[i].layer, probes[i].face);
		end
		pin_on = 1'b0;

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			program_layout(pick_layout(p));
			if (p == PHASES - 1)
				calm = 1'b1;
			for (int n = 0; n < PHASE_REQS; n++) begin
				// let the pipeline run dry mid-phase
				if (p == 4 && n == PHASE_REQS / 2)
					drain_results();
				random_query();
			end
		end

		drain_results();
		repeat (LATENCY + 4) @(negedge clk);
		if (errors == 0 && pending_locs.size() == 0) begin
			$display("** mipmap_subimage_offset_unit: PASSED **");
		end else begin
			$display("** mipmap_subimage_offset_unit: FAILED **");
		end
		$finish;
	end

endmodule

FILE: mipmap_subimage_offset_unit.f
sv/msof_pkg.sv
sv/msof_cfg_regs.sv
sv/msof_entry.sv
sv/msof_level.sv
sv/msof_finish.sv
sv/mipmap_subimage_offset_unit.sv
verif/mipmap_subimage_offset_unit_tb.sv
